### rtl/cspt_pkg.sv
// Shared types, constants and lookup functions for the camera-space point transform.
// Depends on nothing; every rtl file imports it.
package cspt_pkg;

	localparam int MAX_VIEWS       = 8;
	localparam int ROTATION_STAGES = 16;
	localparam int SQRT_STEPS      = 32;
	localparam int CW              = 35;   // cordic x/y width, covers gain growth
	localparam int ZW              = 34;   // cordic angle accumulator width

	localparam logic [31:0] PI_Q30       = 32'd3373259426;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	// configuration register indexes
	localparam logic [2:0] REG_CAM_X      = 3'd0;
	localparam logic [2:0] REG_CAM_Y      = 3'd1;
	localparam logic [2:0] REG_CAM_Z      = 3'd2;
	localparam logic [2:0] REG_HEADING    = 3'd3;
	localparam logic [2:0] REG_VIEW_COUNT = 3'd4;

	typedef struct packed {
		logic [63:0] num;
		logic [63:0] res;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 bypass;
	} rot_t;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
	} offs_t;

	typedef struct packed {
		logic [2:0]         view;
		logic               last;
		logic signed [31:0] dz;
		logic [31:0]        len;
	} view_meta_t;

	// clamp to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) r = 32'sh7fffffff;
		else if (v < -68'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// atan(2^-i) in radians, Q0.30
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			5'd24: r = 30'd63;
			5'd25: r = 30'd31;
			5'd26: r = 30'd15;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			5'd30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// floor(k * 65536 / n) for the view spacing
	function automatic logic [15:0] view_step(input logic [3:0] n, input logic [2:0] k);
		logic [15:0] r;
		unique case (n)
			4'd2: r = {k[0], 15'd0};
			4'd4: r = {k[1:0], 14'd0};
			4'd8: r = {k, 13'd0};
			4'd3: begin
				unique case (k)
					3'd1: r = 16'd21845;
					3'd2: r = 16'd43690;
					default: r = 16'd0;
				endcase
			end
			4'd5: begin
				unique case (k)
					3'd1: r = 16'd13107;
					3'd2: r = 16'd26214;
					3'd3: r = 16'd39321;
					3'd4: r = 16'd52428;
					default: r = 16'd0;
				endcase
			end
			4'd6: begin
				unique case (k)
					3'd1: r = 16'd10922;
					3'd2: r = 16'd21845;
					3'd3: r = 16'd32768;
					3'd4: r = 16'd43690;
					3'd5: r = 16'd54613;
					default: r = 16'd0;
				endcase
			end
			4'd7: begin
				unique case (k)
					3'd1: r = 16'd9362;
					3'd2: r = 16'd18724;
					3'd3: r = 16'd28086;
					3'd4: r = 16'd37449;
					3'd5: r = 16'd46811;
					3'd6: r = 16'd56173;
					default: r = 16'd0;
				endcase
			end
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/cspt_sqrt_cell.sv
// One restoring square-root step: a cell of the distance chain.
// Depends on cspt_pkg.
module cspt_sqrt_cell import cspt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  sqrt_t       din,
	input  logic [63:0] sbit,
	output logic        vld,
	output sqrt_t       dout
);

	logic        vld_q;
	sqrt_t       data_q;
	sqrt_t       nxt;
	logic [63:0] trial;

	// try the next result bit
	always_comb begin
		trial = din.res + sbit;
		if (din.num >= trial) begin
			nxt.num = din.num - trial;
			nxt.res = (din.res >> 1) + sbit;
		end else begin
			nxt.num = din.num;
			nxt.res = din.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= nxt;
	end

	assign vld  = vld_q;
	assign dout = data_q;

endmodule

### rtl/cspt_cordic_cell.sv
// One CORDIC rotation micro-step: a cell of the rotation chain.
// Depends on cspt_pkg.
module cspt_cordic_cell import cspt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  rot_t        din,
	input  logic [4:0]  shift,
	input  logic [29:0] atan,
	output logic        vld,
	output rot_t        dout
);

	logic                 vld_q;
	rot_t                 data_q;
	rot_t                 nxt;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [ZW-1:0] za;

	// steer toward zero residual angle; bypassed words pass untouched
	always_comb begin
		dx  = din.y >>> shift;
		dy  = din.x >>> shift;
		za  = $signed({{(ZW-30){1'b0}}, atan});
		nxt = din;
		if (!din.bypass) begin
			if (!din.z[ZW-1]) begin
				nxt.x = din.x - dx;
				nxt.y = din.y + dy;
				nxt.z = din.z - za;
			end else begin
				nxt.x = din.x + dx;
				nxt.y = din.y - dy;
				nxt.z = din.z + za;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= nxt;
	end

	assign vld  = vld_q;
	assign dout = data_q;

endmodule

### rtl/camera_space_point_transform.sv
// The first view word of a point passes 3 offset/square/sum stages, 32 square-root cells,
// the view sequencer, the quadrant stage, 16 CORDIC cells, gain and output.
// Throughput: one word per cycle while out_ready allows; a point holds the view sequencer
// for its n views (n = effective view count, 1..8); the next point enters with the last view.
// Reset (arst_n low, asynchronous): camera position and heading zero, view count one,
// all pipeline valids cleared.
module camera_space_point_transform import cspt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         view_index,
	output logic signed [31:0] rel_x,
	output logic signed [31:0] rel_y,
	output logic signed [31:0] rel_z,
	output logic [31:0]        distance,
	output logic               last_view
);

	localparam int FM = SQRT_STEPS + 3;

	// configuration registers
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [15:0]        heading_q;
	logic [3:0]         view_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q      <= '0;
			cam_y_q      <= '0;
			cam_z_q      <= '0;
			heading_q    <= '0;
			view_count_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CAM_X:      cam_x_q      <= cfg_data;
				REG_CAM_Y:      cam_y_q      <= cfg_data;
				REG_CAM_Z:      cam_z_q      <= cfg_data;
				REG_HEADING:    heading_q    <= cfg_data[15:0];
				REG_VIEW_COUNT: view_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// handshake control
	logic front_adv, back_adv, seq_take, view_last;
	logic busy_q;
	logic [2:0] k_q;
	logic [3:0] n_q;
	logic out_valid_q;

	logic  fv1_q, fv2_q, fv3_q;
	offs_t fmeta_q [FM];
	logic signed [63:0] sqx_q, sqy_q, sqz_q;
	logic [63:0] sum_q;

	logic  sq_v [SQRT_STEPS+1];
	sqrt_t sq_d [SQRT_STEPS+1];

	assign back_adv  = !out_valid_q || out_ready;
	assign view_last = ({1'b0, k_q} + 4'd1) == n_q;
	assign seq_take  = sq_v[SQRT_STEPS] && (!busy_q || (back_adv && view_last));
	assign front_adv = !sq_v[SQRT_STEPS] || seq_take;
	assign in_ready  = front_adv;

	// offset, squares, sum of squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv1_q <= 1'b0;
			fv2_q <= 1'b0;
			fv3_q <= 1'b0;
		end else if (front_adv) begin
			fv1_q <= in_valid;
			fv2_q <= fv1_q;
			fv3_q <= fv2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (front_adv) begin
			fmeta_q[0].dx <= sat32(68'(point_x) - 68'(cam_x_q));
			fmeta_q[0].dy <= sat32(68'(point_y) - 68'(cam_y_q));
			fmeta_q[0].dz <= sat32(68'(point_z) - 68'(cam_z_q));
			sqx_q <= 64'(fmeta_q[0].dx) * 64'(fmeta_q[0].dx);
			sqy_q <= 64'(fmeta_q[0].dy) * 64'(fmeta_q[0].dy);
			sqz_q <= 64'(fmeta_q[0].dz) * 64'(fmeta_q[0].dz);
			sum_q <= 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);
			for (int i = 1; i < FM; i++) fmeta_q[i] <= fmeta_q[i-1];
		end
	end

	// square-root chain
	assign sq_v[0] = fv3_q;
	assign sq_d[0] = '{num: sum_q, res: 64'd0};

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [63:0] SBIT = 64'd1 << (62 - 2 * i);
		cspt_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (front_adv),
			.vld_in (sq_v[i]),
			.din    (sq_d[i]),
			.sbit   (SBIT),
			.vld    (sq_v[i+1]),
			.dout   (sq_d[i+1])
		);
	end

	// view sequencer: holds one point and issues one view per cycle while the output advances
	logic signed [31:0] sdx_q, sdy_q, sdz_q;
	logic [31:0]        sdist_q;
	logic [3:0]         n_eff;

	always_comb begin
		if (view_count_q == 4'd0) n_eff = 4'd1;
		else if (view_count_q > 4'(MAX_VIEWS)) n_eff = 4'(MAX_VIEWS);
		else n_eff = view_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			n_q    <= 4'd1;
		end else if (seq_take) begin
			busy_q <= 1'b1;
			k_q    <= '0;
			n_q    <= n_eff;
		end else if (busy_q && back_adv) begin
			k_q <= k_q + 3'd1;
			if (view_last) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_take) begin
			sdx_q   <= fmeta_q[FM-1].dx;
			sdy_q   <= fmeta_q[FM-1].dy;
			sdz_q   <= fmeta_q[FM-1].dz;
			sdist_q <= (sq_d[SQRT_STEPS].res[63:32] != 32'd0) ? 32'hffffffff
			                                                  : sq_d[SQRT_STEPS].res[31:0];
		end
	end

	// quadrant stage: angle, exact quarter turns, residual angle in radians
	logic [15:0]          ang, angq, r;
	logic [1:0]           quad;
	logic [13:0]          rabs;
	logic [45:0]          zprod;
	logic [30:0]          zmag;
	logic signed [CW-1:0] xs, ys;
	rot_t                 pre;

	always_comb begin
		ang   = 16'd0 - heading_q - view_step(n_q, k_q);
		angq  = ang + 16'd8192;
		quad  = angq[15:14];
		r     = ang - {quad, 14'd0};
		rabs  = r[15] ? 14'(16'd0 - r) : r[13:0];
		zprod = 46'(rabs) * 46'(PI_Q30);
		zmag  = 31'((zprod + 46'd16384) >> 15);
		xs    = CW'(sdx_q);
		ys    = CW'(sdy_q);
		unique case (quad)
			2'd1: begin pre.x = -ys; pre.y = xs;  end
			2'd2: begin pre.x = -xs; pre.y = -ys; end
			2'd3: begin pre.x = ys;  pre.y = -xs; end
			default: begin pre.x = xs; pre.y = ys; end
		endcase
		pre.z      = r[15] ? -$signed(ZW'(zmag)) : $signed(ZW'(zmag));
		pre.bypass = (r == 16'd0);
	end

	localparam int BM = ROTATION_STAGES + 1;
	logic       rot_v [BM];
	rot_t       rot_d [BM];
	view_meta_t bmeta_q [BM];
	logic       rv0_q;
	rot_t       rot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv0_q <= 1'b0;
		else if (back_adv) rv0_q <= busy_q;
	end

	always_ff @(posedge clk) begin
		if (back_adv) begin
			rot0_q          <= pre;
			bmeta_q[0].view <= k_q;
			bmeta_q[0].last <= view_last;
			bmeta_q[0].dz   <= sdz_q;
			bmeta_q[0].len  <= sdist_q;
			for (int i = 1; i < BM; i++) bmeta_q[i] <= bmeta_q[i-1];
		end
	end

	// rotation chain
	assign rot_v[0] = rv0_q;
	assign rot_d[0] = rot0_q;

	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
		cspt_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (back_adv),
			.vld_in (rot_v[i]),
			.din    (rot_d[i]),
			.shift  (5'(i)),
			.atan   (atan_q30(5'(i))),
			.vld    (rot_v[i+1]),
			.dout   (rot_d[i+1])
		);
	end

	// gain correction product
	logic                 g_v_q;
	logic signed [65:0]   gx_q, gy_q;
	logic signed [CW-1:0] bx_q, by_q;
	logic                 gbyp_q;
	view_meta_t           gmeta_q;
	logic signed [65:0]   inv_gain;

	assign inv_gain = $signed({36'd0, INV_GAIN_Q30});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) g_v_q <= 1'b0;
		else if (back_adv) g_v_q <= rot_v[ROTATION_STAGES];
	end

	always_ff @(posedge clk) begin
		if (back_adv) begin
			gx_q    <= 66'(rot_d[ROTATION_STAGES].x) * inv_gain;
			gy_q    <= 66'(rot_d[ROTATION_STAGES].y) * inv_gain;
			bx_q    <= rot_d[ROTATION_STAGES].x;
			by_q    <= rot_d[ROTATION_STAGES].y;
			gbyp_q  <= rot_d[ROTATION_STAGES].bypass;
			gmeta_q <= bmeta_q[BM-1];
		end
	end

	// round, saturate and hold the output word
	logic signed [67:0] rx_rnd, ry_rnd;
	logic signed [31:0] rx_s, ry_s;
	logic [2:0]         ov_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic [31:0]        od_q;
	logic               ol_q;

	always_comb begin
		rx_rnd = (68'(gx_q) + 68'sd536870912) >>> 30;
		ry_rnd = (68'(gy_q) + 68'sd536870912) >>> 30;
		rx_s   = gbyp_q ? sat32(68'(bx_q)) : sat32(rx_rnd);
		ry_s   = gbyp_q ? sat32(68'(by_q)) : sat32(ry_rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (back_adv) out_valid_q <= g_v_q;
	end

	always_ff @(posedge clk) begin
		if (back_adv) begin
			ov_q <= gmeta_q.view;
			ox_q <= rx_s;
			oy_q <= ry_s;
			oz_q <= gmeta_q.dz;
			od_q <= gmeta_q.len;
			ol_q <= gmeta_q.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign view_index = ov_q;
	assign rel_x      = ox_q;
	assign rel_y      = oy_q;
	assign rel_z      = oz_q;
	assign distance   = od_q;
	assign last_view  = ol_q;

endmodule

### dv/camera_space_point_transform_tb.sv
// Self-checking testbench for camera_space_point_transform: directed table and camera setups, then random points.
// Depends on rtl/cspt_pkg.sv and rtl/camera_space_point_transform.sv.
`timescale 1ns / 1ps

module camera_space_point_transform_tb;
	import cspt_pkg::*;

	localparam int LIMIT = 400000;

	// indexes past the register list; writes there are ignored
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [2:0]         view;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic [31:0]        len;
		logic               last;
	} view_word_t;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
	} xy_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               known;
		view_word_t         word;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_addr;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         view_index;
	logic signed [31:0] rel_x;
	logic signed [31:0] rel_y;
	logic signed [31:0] rel_z;
	logic [31:0]        distance;
	logic               last_view;

	// shadow copy of the camera registers
	logic [31:0] sh_cam_x, sh_cam_y, sh_cam_z;
	logic [15:0] sh_heading;
	logic [3:0]  sh_views;

	view_word_t pending_views[$];
	int         fail_count = 0;
	int         points_sent;
	int         words_seen = 0;
	int         cycles = 0;
	int         stall_left = 0;
	longint     atan_tab[16];

	camera_space_point_transform uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run-time limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stalls: mostly short, a few long, calm stretches between
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each accepted view word against the oldest expectation
	always @(posedge clk) begin
		view_word_t want;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (pending_views.size() == 0) begin
				$error("unexpected word: view_index %0d", view_index);
				fail_count++;
			end else begin
				want = pending_views.pop_front();
				if (view_index !== want.view) begin
					$error("view_index: expected %0d, got %0d", want.view, view_index);
					fail_count++;
				end
				if (rel_x !== want.rx) begin
					$error("rel_x: expected %0d, got %0d", want.rx, rel_x);
					fail_count++;
				end
				if (rel_y !== want.ry) begin
					$error("rel_y: expected %0d, got %0d", want.ry, rel_y);
					fail_count++;
				end
				if (rel_z !== want.rz) begin
					$error("rel_z: expected %0d, got %0d", want.rz, rel_z);
					fail_count++;
				end
				if (distance !== want.len) begin
					$error("distance: expected %0d, got %0d", want.len, distance);
					fail_count++;
				end
				if (last_view !== want.last) begin
					$error("last_view: expected %0d, got %0d", want.last, last_view);
					fail_count++;
				end
			end
		end
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// counterclockwise yaw by a 16-bit turn fraction
	function automatic xy_t yaw_turn(longint x0, longint y0, logic [15:0] a);
		longint x, y, t, z, dx, dy;
		longint unsigned m;
		int q, r;
		xy_t o;
		x = x0;
		y = y0;
		if (a != 0) begin
			q = ((int'(a) + 8192) >> 14) & 3;
			r = (int'(a) - q * 16384) & 16'hffff;
			if (r >= 32768) r -= 65536;
			if (q == 1) begin
				t = x; x = -y; y = t;
			end else if (q == 2) begin
				x = -x; y = -y;
			end else if (q == 3) begin
				t = x; x = y; y = -t;
			end
			if (r != 0) begin
				m = longint'(r < 0 ? -r : r) * 64'd3373259426;
				z = longint'((m + 64'd16384) >> 15);
				if (r < 0) z = -z;
				for (int i = 0; i < 16; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (z >= 0) begin
						x -= dx; y += dy; z -= atan_tab[i];
					end else begin
						x += dx; y -= dy; z += atan_tab[i];
					end
				end
				x = (x * 64'sd652032874 + (64'sd1 << 29)) >>> 30;
				y = (y * 64'sd652032874 + (64'sd1 << 29)) >>> 30;
			end
		end
		o.x = clamp32(x);
		o.y = clamp32(y);
		return o;
	endfunction

	// expected view words of one point under the current registers
	function automatic void predict_views(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		longint dx, dy, dz;
		longint unsigned num, res, bitv;
		int n;
		logic [15:0] ang;
		xy_t rot;
		view_word_t w;
		dx = clamp32(longint'(px) - longint'($signed(sh_cam_x)));
		dy = clamp32(longint'(py) - longint'($signed(sh_cam_y)));
		dz = clamp32(longint'(pz) - longint'($signed(sh_cam_z)));
		num = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
		res = 0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (num >= res + bitv) begin
				num -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		if (res > 64'hffffffff) res = 64'hffffffff;
		n = sh_views;
		if (n == 0) n = 1;
		if (n > MAX_VIEWS) n = MAX_VIEWS;
		if (n > 8) n = 8;
		for (int k = 0; k < n; k++) begin
			ang = 16'(0 - (int'(sh_heading) + (k * 65536) / n));
			rot = yaw_turn(dx, dy, ang);
			w.view = k[2:0];
			w.rx = rot.x[31:0];
			w.ry = rot.y[31:0];
			w.rz = dz[31:0];
			w.len = res[31:0];
			w.last = (k + 1 == n);
			pending_views.push_back(w);
		end
	endfunction

	// register write, enable left high for back-to-back writes
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_CAM_X:      sh_cam_x = data;
			REG_CAM_Y:      sh_cam_y = data;
			REG_CAM_Z:      sh_cam_z = data;
			REG_HEADING:    sh_heading = data[15:0];
			REG_VIEW_COUNT: sh_views = data[3:0];
			default: ;
		endcase
	endtask

	task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [15:0] hd, logic [3:0] vc);
		write_reg(REG_CAM_X, cx);
		write_reg(REG_CAM_Y, cy);
		write_reg(REG_CAM_Z, cz);
		write_reg(REG_HEADING, {16'($urandom_range(0, 65535)), hd});
		write_reg(REG_VIEW_COUNT, {28'($urandom), vc});
		cfg_we <= 1'b0;
	endtask

	// drop valid, let every expected word drain, then wait out the pipeline
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_views.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5) return 0;
		if (p < 9) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return ($urandom_range(0, 1)) ? 32'h80000000 : 32'h7fffffff;
			2: return 32'($urandom_range(0, 32'h00400000)) - 32'h00200000;
			default: return 32'($urandom_range(0, 32'h0fffffff)) - 32'h08000000;
		endcase
	endfunction

	// one point on the input channel; valid stays high afterwards
	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, int gap, logic known, view_word_t word);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		do @(posedge clk); while (!in_ready);
		points_sent++;
		if (known) pending_views.push_back(word);
		else predict_views(x, y, z);
	endtask

	row_t reset_rows[8];
	view_word_t none;

	initial begin
		atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767};
		points_sent = 0;
		none = '0;
		sh_cam_x = 0; sh_cam_y = 0; sh_cam_z = 0; sh_heading = 0; sh_views = 1;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
		in_valid = 1'b0;
		point_x = '0; point_y = '0; point_z = '0;

		// after reset: identity rotation, one view, zero camera
		reset_rows[0] = '{0, 0, 0, 1'b1, '{3'd0, 0, 0, 0, 32'd0, 1'b1}};
		reset_rows[1] = '{196608, 262144, 0, 1'b1, '{3'd0, 196608, 262144, 0, 32'd327680, 1'b1}};
		reset_rows[2] = '{32'sh80000000, 0, 0, 1'b1,
			'{3'd0, 32'sh80000000, 0, 0, 32'h80000000, 1'b1}};
		reset_rows[3] = '{32'sh7fffffff, 0, 0, 1'b1,
			'{3'd0, 32'sh7fffffff, 0, 0, 32'h7fffffff, 1'b1}};
		reset_rows[4] = '{0, 0, 32'sh80000000, 1'b1,
			'{3'd0, 0, 0, 32'sh80000000, 32'h80000000, 1'b1}};
		reset_rows[5] = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, none};
		reset_rows[6] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, none};
		reset_rows[7] = '{-65536, 32'sh7fffffff, 12345, 1'b0, none};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_rows[i])
			send_point(reset_rows[i].x, reset_rows[i].y, reset_rows[i].z, pick_gap(),
				reset_rows[i].known, reset_rows[i].word);
		drain();

		// quarter turns, offset overflow, view count zero and past the top
		write_reg(REG_UNUSED_LO, 32'hffffffff);
		write_reg(REG_UNUSED_HI, 32'h0);
		set_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'd16384, 4'd0);
		send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 1'b0, none);
		send_point(0, 0, 0, 1, 1'b0, none);
		drain();
		set_camera(32'd0, 32'd0, 32'd0, 16'd32768, 4'd4);
		send_point(32'sh80000000, 32'sh00010000, 7, 0, 1'b0, none);
		send_point(32'sh00030000, 32'sh80000000, -7, 0, 1'b0, none);
		drain();
		set_camera(32'h00010000, 32'hffff0000, 32'd5, 16'd49152, 4'd15);
		send_point(32'sh7fffffff, 32'sh80000000, 32'sh40000000, 0, 1'b0, none);
		send_point(32'sh00123456, -32'sh00654321, 0, 2, 1'b0, none);
		drain();
		set_camera(32'd0, 32'd0, 32'd0, 16'd65535, 4'd9);
		send_point(32'sh01000000, 32'sh00800000, 0, 0, 1'b0, none);
		drain();

		// random phases
		for (int ph = 0; ph < 10; ph++) begin
			set_camera(pick_coord(), pick_coord(), pick_coord(),
				($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 16384) : 16'($urandom),
				(ph == 0) ? 4'd8 : (ph == 1) ? 4'd1 : 4'($urandom));
			for (int i = 0; i < 10; i++) begin
				if (ph == 4 && i == 5) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_views.size() != 0) @(posedge clk);
				end
				send_point(pick_coord(), pick_coord(), pick_coord(),
					(ph == 2) ? 0 : pick_gap(), 1'b0, none);
			end
			drain();
		end

		if (pending_views.size() != 0)
			$error("%0d expected words never arrived", pending_views.size());
		$display("covered %0d points and %0d view words over directed and random camera setups",
			points_sent, words_seen);
		$display("mismatches: %0d", fail_count);
		if (fail_count == 0 && pending_views.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
